FILE: rtl/core/eodm_pkg.sv
// Package for the edit-distance-one dictionary matcher.
// Holds sizes, derived widths and result status codes; depends on nothing.
`default_nettype none

package eodm_pkg;

  // Store sizes.
  localparam int MAX_WORDS = 64;
  localparam int MAX_LEN   = 16;

  // Fixed field widths of the channels.
  localparam int LETTER_W = 8;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 6;

  // Derived widths.
  localparam int CNT_W       = $clog2(MAX_WORDS + 1);
  localparam int W_W         = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int LEN_W       = $clog2(MAX_LEN + 1);
  localparam int POS_W       = $clog2(MAX_LEN);
  localparam int ADDR_W      = W_W + POS_W;
  localparam int DCHAR_DEPTH = MAX_WORDS << POS_W;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_CORRECT   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CANDIDATE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DROPPED   = 2'd3;

endpackage

`default_nettype wire

FILE: rtl/core/eodm_if.sv
// Channel interfaces of the dictionary matcher: character input and result output.
// Depends on eodm_pkg for field widths.
`default_nettype none

interface eodm_in_if import eodm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [LETTER_W-1:0] letter;
  logic                word_end;

  modport source (output valid, kind, letter, word_end, input ready);
  modport sink   (input valid, kind, letter, word_end, output ready);
endinterface

interface eodm_out_if import eodm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  word_index;
  logic                last;

  modport source (output valid, status, word_index, last, input ready);
  modport sink   (input valid, status, word_index, last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/edit_one_dictionary_matcher.sv
// Top level of the edit-distance-one dictionary matcher.
// Depends on eodm_pkg and the channel interfaces in eodm_if.sv.
//
//   Channel   Direction  Beat contents
//   in_chan   sink       kind, letter, word_end
//   out_chan  source     status, word_index, last
//
// A query word end starts a pass over the stored words for an exact match and, if none is
// found, a second pass for candidates. Each word is read in S_LEN and screened by length
// in S_CHK; one not ruled out is scanned in S_SCAN and judged in S_EVAL; S_FLUSH sends the
// final result. The scan speed is set by the single read port of the character memory,
// one byte a cycle. Reset clears counters and flags; the memories are not cleared.
// in_chan.ready is low during a search and while a result waits that is not taken.
`default_nettype none

module edit_one_dictionary_matcher import eodm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  eodm_in_if.sink    in_chan,
  eodm_out_if.source out_chan
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LEN   = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  // Memories and query storage.
  logic [LETTER_W-1:0] dchar_mem [DCHAR_DEPTH];
  logic [LEN_W-1:0]    dlen_mem  [MAX_WORDS];
  logic [LETTER_W-1:0] query_r   [MAX_LEN];
  logic [LETTER_W-1:0] qshift_r  [MAX_LEN];
  logic [LETTER_W-1:0] dchar_rd_r;
  logic [LEN_W-1:0]    dlen_rd_r;

  // Control state.
  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] word_count_r, word_count_nxt;
  logic [LEN_W-1:0] build_pos_r, build_pos_nxt;
  logic [LEN_W-1:0] qlen_r, qlen_nxt;
  logic [CNT_W-1:0] w_r, w_nxt;
  logic             pass2_r, pass2_nxt;
  logic [LEN_W-1:0] scan_len_r, scan_len_nxt;
  logic [LEN_W-1:0] iss_r, iss_nxt;
  logic [LEN_W-1:0] proc_r, proc_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             len_same_r, len_same_nxt;
  logic             d_long_r, d_long_nxt;
  logic             q_long_r, q_long_nxt;
  logic             prefix_r, prefix_nxt;
  logic [1:0]       mis_r, mis_nxt;
  logic             rem_r, rem_nxt;
  logic             ins_r, ins_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  logic [W_W-1:0]   pend_idx_r, pend_idx_nxt;
  logic [LETTER_W-1:0] q_prev_r, d_prev_r;

  // Output register.
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [INDEX_W-1:0]  out_index_r;
  logic                out_last_r;

  // Combinational helpers.
  logic                in_fire, dict_fire, query_fire;
  logic                dict_room, build_room, dchar_we, dlen_we, q_we;
  logic [LEN_W-1:0]    build_pos_plus, qlen_plus;
  logic [ADDR_W-1:0]   dchar_wa, dchar_ra;
  logic                out_free, out_load;
  logic                push_req, push_last;
  logic [STATUS_W-1:0] push_status;
  logic [INDEX_W-1:0]  push_idx;
  logic                qshift_load, qshift_en;
  logic                last_word;
  logic [2:0]          adv_state;
  logic [CNT_W-1:0]    adv_w;
  logic                adv_pass2;
  logic                chk_same, chk_dlong, chk_qlong, chk_scan;
  logic                m_same, m_dq, m_qd;
  logic                exact_hit, cand_hit;

  assign out_free = !out_valid_r || out_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE) && out_free;
  assign in_fire    = in_chan.valid && in_chan.ready;
  assign dict_fire  = in_fire && !in_chan.kind;
  assign query_fire = in_fire && in_chan.kind;

  // Character storage for the dictionary word being built and the query.
  assign dict_room  = word_count_r != CNT_W'(MAX_WORDS);
  assign build_room = build_pos_r != LEN_W'(MAX_LEN);
  assign dchar_we   = dict_fire && dict_room && build_room;
  assign dlen_we    = dict_fire && in_chan.word_end && dict_room;
  assign q_we       = query_fire && (qlen_r != LEN_W'(MAX_LEN));
  assign build_pos_plus = build_pos_r + LEN_W'(dchar_we);
  assign qlen_plus      = qlen_r + LEN_W'(q_we);
  assign dchar_wa = {word_count_r[W_W-1:0], build_pos_r[POS_W-1:0]};
  assign dchar_ra = {w_r[W_W-1:0], iss_r[POS_W-1:0]};

  // Walk to the next stored word, or to the next pass, or finish.
  assign last_word = (w_r + CNT_W'(1)) == word_count_r;
  always_comb begin
    if (last_word) begin
      adv_state = pass2_r ? S_FLUSH : S_LEN;
      adv_w     = pass2_r ? w_r : '0;
      adv_pass2 = 1'b1;
    end else begin
      adv_state = S_LEN;
      adv_w     = w_r + CNT_W'(1);
      adv_pass2 = pass2_r;
    end
  end

  // Length screening of the current word against the query.
  assign chk_same  = dlen_rd_r == qlen_r;
  assign chk_dlong = {1'b0, dlen_rd_r} == ({1'b0, qlen_r} + (LEN_W + 1)'(1));
  assign chk_qlong = {1'b0, qlen_r} == ({1'b0, dlen_rd_r} + (LEN_W + 1)'(1));
  assign chk_scan  = pass2_r ? (chk_same || chk_dlong || chk_qlong) : chk_same;

  // Character compares: same position, dictionary one ahead, query one ahead.
  assign m_same = dchar_rd_r == qshift_r[0];
  assign m_dq   = dchar_rd_r == q_prev_r;
  assign m_qd   = qshift_r[0] == d_prev_r;

  assign exact_hit = len_same_r && prefix_r;
  assign cand_hit  = (len_same_r && (mis_r != 2'd2)) || (d_long_r && rem_r) ||
                     (q_long_r && ins_r);

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    word_count_nxt = word_count_r;
    build_pos_nxt  = build_pos_r;
    qlen_nxt       = qlen_r;
    w_nxt          = w_r;
    pass2_nxt      = pass2_r;
    scan_len_nxt   = scan_len_r;
    iss_nxt        = iss_r;
    proc_nxt       = proc_r;
    rd_vld_nxt     = 1'b0;
    len_same_nxt   = len_same_r;
    d_long_nxt     = d_long_r;
    q_long_nxt     = q_long_r;
    prefix_nxt     = prefix_r;
    mis_nxt        = mis_r;
    rem_nxt        = rem_r;
    ins_nxt        = ins_r;
    pend_vld_nxt   = pend_vld_r;
    pend_idx_nxt   = pend_idx_r;
    push_req       = 1'b0;
    push_status    = ST_NONE;
    push_idx       = '0;
    push_last      = 1'b1;
    qshift_load    = 1'b0;
    qshift_en      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (dict_fire) begin
          if (in_chan.word_end) begin
            build_pos_nxt = '0;
            if (dict_room) begin
              word_count_nxt = word_count_r + CNT_W'(1);
            end else begin
              push_req    = 1'b1;
              push_status = ST_DROPPED;
            end
          end else begin
            build_pos_nxt = build_pos_plus;
          end
        end else if (query_fire) begin
          qlen_nxt = qlen_plus;
          if (in_chan.word_end) begin
            w_nxt        = '0;
            pass2_nxt    = 1'b0;
            pend_vld_nxt = 1'b0;
            state_nxt    = (word_count_r == '0) ? S_FLUSH : S_LEN;
          end
        end
      end
      S_LEN: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (chk_scan) begin
          len_same_nxt = chk_same;
          d_long_nxt   = chk_dlong;
          q_long_nxt   = chk_qlong;
          scan_len_nxt = chk_dlong ? dlen_rd_r : qlen_r;
          iss_nxt      = '0;
          proc_nxt     = '0;
          prefix_nxt   = 1'b1;
          mis_nxt      = 2'd0;
          rem_nxt      = 1'b0;
          ins_nxt      = 1'b0;
          qshift_load  = 1'b1;
          state_nxt    = S_SCAN;
        end else begin
          w_nxt     = adv_w;
          pass2_nxt = adv_pass2;
          state_nxt = adv_state;
        end
      end
      S_SCAN: begin
        // Issue one read a cycle; process the byte returned from the cycle before.
        if (iss_r != scan_len_r) begin
          iss_nxt    = iss_r + LEN_W'(1);
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r) begin
          qshift_en  = 1'b1;
          proc_nxt   = proc_r + LEN_W'(1);
          prefix_nxt = prefix_r && m_same;
          mis_nxt    = (!m_same && (mis_r != 2'd2)) ? mis_r + 2'd1 : mis_r;
          rem_nxt    = (rem_r && m_dq) || prefix_r;
          ins_nxt    = (ins_r && m_qd) || prefix_r;
          if ((proc_r + LEN_W'(1)) == scan_len_r) begin
            state_nxt = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        if (!pass2_r) begin
          if (exact_hit) begin
            push_req    = 1'b1;
            push_status = ST_CORRECT;
            push_idx    = INDEX_W'(w_r[W_W-1:0]);
            if (out_free) begin
              qlen_nxt  = '0;
              state_nxt = S_IDLE;
            end
          end else begin
            w_nxt     = adv_w;
            pass2_nxt = adv_pass2;
            state_nxt = adv_state;
          end
        end else if (cand_hit && pend_vld_r) begin
          // The held candidate is not the last one: send it and hold this one.
          push_req    = 1'b1;
          push_status = ST_CANDIDATE;
          push_idx    = INDEX_W'(pend_idx_r);
          push_last   = 1'b0;
          if (out_free) begin
            pend_idx_nxt = w_r[W_W-1:0];
            w_nxt        = adv_w;
            pass2_nxt    = adv_pass2;
            state_nxt    = adv_state;
          end
        end else begin
          if (cand_hit) begin
            pend_vld_nxt = 1'b1;
            pend_idx_nxt = w_r[W_W-1:0];
          end
          w_nxt     = adv_w;
          pass2_nxt = adv_pass2;
          state_nxt = adv_state;
        end
      end
      S_FLUSH: begin
        push_req    = 1'b1;
        push_status = pend_vld_r ? ST_CANDIDATE : ST_NONE;
        push_idx    = pend_vld_r ? INDEX_W'(pend_idx_r) : '0;
        if (out_free) begin
          pend_vld_nxt = 1'b0;
          qlen_nxt     = '0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_load = push_req && out_free;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      word_count_r <= '0;
      build_pos_r  <= '0;
      qlen_r       <= '0;
      w_r          <= '0;
      pass2_r      <= 1'b0;
      rd_vld_r     <= 1'b0;
      pend_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      word_count_r <= word_count_nxt;
      build_pos_r  <= build_pos_nxt;
      qlen_r       <= qlen_nxt;
      w_r          <= w_nxt;
      pass2_r      <= pass2_nxt;
      rd_vld_r     <= rd_vld_nxt;
      pend_vld_r   <= pend_vld_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Scan working registers and result payload.
  always_ff @(posedge clk) begin
    scan_len_r <= scan_len_nxt;
    iss_r      <= iss_nxt;
    proc_r     <= proc_nxt;
    len_same_r <= len_same_nxt;
    d_long_r   <= d_long_nxt;
    q_long_r   <= q_long_nxt;
    prefix_r   <= prefix_nxt;
    mis_r      <= mis_nxt;
    rem_r      <= rem_nxt;
    ins_r      <= ins_nxt;
    pend_idx_r <= pend_idx_nxt;
    if (qshift_en) begin
      q_prev_r <= qshift_r[0];
      d_prev_r <= dchar_rd_r;
    end
    if (out_load) begin
      out_status_r <= push_status;
      out_index_r  <= push_idx;
      out_last_r   <= push_last;
    end
  end

  // Query characters, and the shifting copy that feeds the compares.
  always_ff @(posedge clk) begin
    if (q_we) begin
      query_r[qlen_r[POS_W-1:0]] <= in_chan.letter;
    end
    if (qshift_load) begin
      for (int i = 0; i < MAX_LEN; i++) begin
        qshift_r[i] <= query_r[i];
      end
    end else if (qshift_en) begin
      for (int i = 0; i < MAX_LEN - 1; i++) begin
        qshift_r[i] <= qshift_r[i + 1];
      end
    end
  end

  // Dictionary character memory: one write port, one registered read port.
  // Writes happen only while idle and read data is used only during a search, so they never meet.
  always_ff @(posedge clk) begin
    if (dchar_we) begin
      dchar_mem[dchar_wa] <= in_chan.letter;
    end
    dchar_rd_r <= dchar_mem[dchar_ra];
  end

  // Dictionary length memory.
  always_ff @(posedge clk) begin
    if (dlen_we) begin
      dlen_mem[word_count_r[W_W-1:0]] <= build_pos_plus;
    end
    dlen_rd_r <= dlen_mem[w_r[W_W-1:0]];
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.word_index = out_index_r;
  assign out_chan.last       = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/core/eodm_checker.sv
// Port-level checks for the dictionary matcher, bound to the top level.
// Depends on eodm_pkg for status codes and widths.
`default_nettype none

module eodm_checker import eodm_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_kind,
  input logic                in_word_end,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [INDEX_W-1:0]  out_word_index,
  input logic                out_last
);

  // A stalled result beat holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_word_index) && $stable(out_last))
    else $error("result beat changed while stalled");

  // The end of a query starts a search, so no beat is taken in the next cycle.
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind && in_word_end |=> !in_ready)
    else $error("input taken right after a query word end");

  // No-candidate and dropped results stand alone and carry index zero.
  a_single_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NONE || out_status == ST_DROPPED) |->
      out_last && (out_word_index == '0))
    else $error("single result without last or with nonzero index");

  // An exact match is always the only result of its query.
  a_correct_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_CORRECT |-> out_last)
    else $error("exact match result without last");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind edit_one_dictionary_matcher eodm_checker u_eodm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .in_kind        (in_chan.kind),
  .in_word_end    (in_chan.word_end),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_status     (out_chan.status),
  .out_word_index (out_chan.word_index),
  .out_last       (out_chan.last)
);

`default_nettype wire
